// ----- src/assert_macros.svh -----
// Assertion macros shared by the data-signature length parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DSL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DSL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dsl_pkg.sv -----
// Shared types, character codes and helpers for the data-signature length parser.
package dsl_pkg;

    localparam int LENGTH_BITS_DEF        = 24;
    localparam int COUNT_BITS_DEF         = 16;
    localparam int ELEMENT_COUNT_BITS_DEF = 8;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SYNTAX   = 2'd1,
        ST_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] sig_byte;
        logic       last;
    } in_word_t;

    localparam logic [7:0] CH_LBRACE   = 8'h7B;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_BSLASH   = 8'h5C;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_DIGIT_0  = 8'h30;
    localparam logic [7:0] CH_DIGIT_9  = 8'h39;
    localparam logic [7:0] CH_UPPER_C  = 8'h43;
    localparam logic [7:0] CH_UPPER_S  = 8'h53;
    localparam logic [7:0] CH_UPPER_L  = 8'h4C;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_C  = 8'h63;
    localparam logic [7:0] CH_LOWER_S  = 8'h73;
    localparam logic [7:0] CH_LOWER_L  = 8'h6C;

    localparam logic [2:0] WIDTH_NONE = 3'd0;
    localparam logic [2:0] WIDTH_1    = 3'd1;
    localparam logic [2:0] WIDTH_2    = 3'd2;
    localparam logic [2:0] WIDTH_4    = 3'd4;

    // Byte width of a type letter, or WIDTH_NONE for anything else.
    function automatic logic [2:0] type_width(input logic [7:0] c);
        logic [2:0] w;
        case (c)
            CH_UPPER_C, CH_LOWER_C, CH_LOWER_A: w = WIDTH_1;
            CH_UPPER_S, CH_LOWER_S:             w = WIDTH_2;
            CH_UPPER_L, CH_LOWER_L:             w = WIDTH_4;
            default:                            w = WIDTH_NONE;
        endcase
        return w;
    endfunction

endpackage

// ----- src/data_signature_length_parser.sv -----
// Top level of the data-signature length parser: input register, parse core, result register.
// A result goes to the result register when the core takes its last word from the input register.
// Throughput: one signature word per cycle; a last word waits in the input register only
// while the previous result in the result register has not been taken.
// Reset: rst_n low clears both valid flags and returns the parse state to the start of a
// signature at once; the payload registers are not reset.
`include "assert_macros.svh"

module data_signature_length_parser
#(
    parameter int LENGTH_BITS        = dsl_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS         = dsl_pkg::COUNT_BITS_DEF,
    parameter int ELEMENT_COUNT_BITS = dsl_pkg::ELEMENT_COUNT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    sig_byte,
    input  logic                          last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LENGTH_BITS-1:0]        packed_length,
    output logic [ELEMENT_COUNT_BITS-1:0] element_count,
    output logic                          is_record,
    output logic [1:0]                    status
);

    // Each accepted word sits in the input register until the core takes it; the core then folds
    // its character into the parse state. Only a last word produces a result, and it
    // needs the result register to be free, so ordinary words never stall on the output.

    logic                          word_valid;
    dsl_pkg::in_word_t             word;
    logic                          take;
    logic                          result_load;
    logic                          out_free;
    logic [LENGTH_BITS-1:0]        res_length;
    logic [ELEMENT_COUNT_BITS-1:0] res_count;
    logic                          res_record;
    dsl_pkg::status_t              res_status;

    dsl_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sig_byte   (sig_byte),
        .last       (last),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    dsl_parse_core
    #(
        .LENGTH_BITS        (LENGTH_BITS),
        .COUNT_BITS         (COUNT_BITS),
        .ELEMENT_COUNT_BITS (ELEMENT_COUNT_BITS)
    )
    u_parse_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .word_valid  (word_valid),
        .word        (word),
        .out_free    (out_free),
        .take        (take),
        .result_load (result_load),
        .res_length  (res_length),
        .res_count   (res_count),
        .res_record  (res_record),
        .res_status  (res_status)
    );

    dsl_out_stage
    #(
        .LENGTH_BITS        (LENGTH_BITS),
        .ELEMENT_COUNT_BITS (ELEMENT_COUNT_BITS)
    )
    u_out_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (result_load),
        .res_length    (res_length),
        .res_count     (res_count),
        .res_record    (res_record),
        .res_status    (res_status),
        .out_ready     (out_ready),
        .out_free      (out_free),
        .out_valid     (out_valid),
        .packed_length (packed_length),
        .element_count (element_count),
        .is_record     (is_record),
        .status        (status)
    );

    // A new result must come from a last word processed in the cycle before.
    `DSL_ASSERT_NXT(a_result_from_last, !out_valid,
        !out_valid || $past(word_valid && word.last),
        "result appeared without a last word")

    // A pending result that is not taken must never be overwritten.
    `DSL_ASSERT_IMP(a_no_overwrite, word_valid && word.last && out_valid && !out_ready,
        !take, "pending result overwritten")

    // A syntax error always reports zero length and zero elements.
    `DSL_ASSERT_IMP(a_syntax_zero, out_valid && (status == dsl_pkg::ST_SYNTAX),
        (packed_length == '0) && (element_count == '0), "syntax error with non-zero fields")

    // An empty input register always accepts a word.
    `DSL_ASSERT_IMP(a_empty_ready, !word_valid, in_ready, "input register empty but not ready")

endmodule

// ----- src/dsl_in_stage.sv -----
// Input register holding one signature word until the parse core takes it.
module dsl_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        sig_byte,
    input  logic              last,
    input  logic              take,
    output logic              word_valid,
    output dsl_pkg::in_word_t word
);

    logic              valid_reg;
    logic              valid_next;
    dsl_pkg::in_word_t word_reg;

    // The register may refill in the same cycle that the core drains it.
    assign in_ready   = !valid_reg || take;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg.sig_byte <= sig_byte;
            word_reg.last     <= last;
        end
    end

    assign word_valid = valid_reg;
    assign word       = word_reg;

endmodule

// ----- src/dsl_parse_core.sv -----
// Parse state registers and the per-character next-state logic.
module dsl_parse_core
#(
    parameter int LENGTH_BITS        = dsl_pkg::LENGTH_BITS_DEF,
    parameter int COUNT_BITS         = dsl_pkg::COUNT_BITS_DEF,
    parameter int ELEMENT_COUNT_BITS = dsl_pkg::ELEMENT_COUNT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          word_valid,
    input  dsl_pkg::in_word_t             word,
    input  logic                          out_free,
    output logic                          take,
    output logic                          result_load,
    output logic [LENGTH_BITS-1:0]        res_length,
    output logic [ELEMENT_COUNT_BITS-1:0] res_count,
    output logic                          res_record,
    output dsl_pkg::status_t              res_status
);

    localparam int PROD_W = COUNT_BITS + 2;
    localparam int SUM_W  = ((LENGTH_BITS > PROD_W) ? LENGTH_BITS : PROD_W) + 1;
    localparam int ACC_W  = COUNT_BITS + 4;

    localparam logic [LENGTH_BITS-1:0]        LEN_MAX = '1;
    localparam logic [COUNT_BITS-1:0]         CNT_MAX = '1;
    localparam logic [ELEMENT_COUNT_BITS-1:0] ELC_MAX = '1;

    typedef enum logic [10:0] {
        PH_START       = 11'b000_0000_0001,
        PH_ELEM        = 11'b000_0000_0010,
        PH_NAME        = 11'b000_0000_0100,
        PH_TYPE        = 11'b000_0000_1000,
        PH_AFTER_TYPE  = 11'b000_0001_0000,
        PH_COUNT_FIRST = 11'b000_0010_0000,
        PH_COUNT_MORE  = 11'b000_0100_0000,
        PH_AFTER_COUNT = 11'b000_1000_0000,
        PH_LIMIT       = 11'b001_0000_0000,
        PH_DONE        = 11'b010_0000_0000,
        PH_ERROR       = 11'b100_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t                        ph;
        logic                          esc;
        logic                          rec;
        logic [COUNT_BITS-1:0]         cnt;
        logic [2:0]                    w;
        logic [LENGTH_BITS-1:0]        len;
        logic [ELEMENT_COUNT_BITS-1:0] elc;
        dsl_pkg::status_t              err;
    } parse_st_t;

    localparam parse_st_t ST_RESET = '{
        ph:  PH_START,
        esc: 1'b0,
        rec: 1'b0,
        cnt: '0,
        w:   dsl_pkg::WIDTH_NONE,
        len: '0,
        elc: '0,
        err: dsl_pkg::ST_OK
    };

    parse_st_t st_reg;
    parse_st_t st_next;
    parse_st_t stepped;

    function automatic parse_st_t syn_err(input parse_st_t s);
        parse_st_t r;
        r     = s;
        r.err = dsl_pkg::ST_SYNTAX;
        r.ph  = PH_ERROR;
        return r;
    endfunction

    function automatic dsl_pkg::status_t flag_ovf(input dsl_pkg::status_t e);
        return (e == dsl_pkg::ST_OK) ? dsl_pkg::ST_OVERFLOW : e;
    endfunction

    // Adds the element just closed to the running length and element count, saturating and flagging overflow.
    function automatic parse_st_t finish_elem(input parse_st_t s);
        parse_st_t             r;
        logic [COUNT_BITS-1:0] n;
        logic [PROD_W-1:0]     prod;
        logic [SUM_W-1:0]      sum;
        r = s;
        n = (s.cnt == '0) ? COUNT_BITS'(1) : s.cnt;
        case (s.w)
            dsl_pkg::WIDTH_4: prod = {n, 2'b00};
            dsl_pkg::WIDTH_2: prod = {1'b0, n, 1'b0};
            default:          prod = {2'b00, n};
        endcase
        sum = SUM_W'(s.len) + SUM_W'(prod);
        if (sum > SUM_W'(LEN_MAX))
        begin
            r.len = LEN_MAX;
            r.err = flag_ovf(r.err);
        end
        else
        begin
            r.len = sum[LENGTH_BITS-1:0];
        end
        if (s.elc == ELC_MAX)
        begin
            r.err = flag_ovf(r.err);
        end
        else
        begin
            r.elc = s.elc + 1'b1;
        end
        r.cnt = '0;
        r.w   = dsl_pkg::WIDTH_NONE;
        r.esc = 1'b0;
        r.ph  = s.rec ? PH_ELEM : PH_DONE;
        return r;
    endfunction

    // First character of an element: closing brace, opening quote or a type letter.
    function automatic parse_st_t start_elem(input parse_st_t s, input logic [7:0] c);
        parse_st_t  r;
        logic [2:0] w;
        r = s;
        w = dsl_pkg::type_width(c);
        if (s.rec && (c == dsl_pkg::CH_RBRACE))
        begin
            r.ph = PH_DONE;
        end
        else if (c == dsl_pkg::CH_QUOTE)
        begin
            r.esc = 1'b0;
            r.ph  = PH_NAME;
        end
        else if (w != dsl_pkg::WIDTH_NONE)
        begin
            r.w   = w;
            r.cnt = '0;
            r.ph  = PH_AFTER_TYPE;
        end
        else
        begin
            r = syn_err(r);
        end
        return r;
    endfunction

    logic [7:0]            c;
    logic                  do_finish;
    logic                  do_start;
    logic [2:0]            tw;
    logic [ACC_W-1:0]      acc;
    parse_st_t             s;

    assign c  = word.sig_byte;
    assign tw = dsl_pkg::type_width(c);
    assign acc = ACC_W'({st_reg.cnt, 3'b000}) + ACC_W'({st_reg.cnt, 1'b0}) + ACC_W'(c[3:0]);

    always_comb
    begin
        s         = st_reg;
        do_finish = 1'b0;
        do_start  = 1'b0;
        case (st_reg.ph)
            PH_START:
            begin
                if (c == dsl_pkg::CH_LBRACE)
                begin
                    s.rec = 1'b1;
                    s.ph  = PH_ELEM;
                end
                else
                begin
                    do_start = 1'b1;
                end
            end
            PH_ELEM:
            begin
                do_start = 1'b1;
            end
            PH_NAME:
            begin
                if (st_reg.esc)
                begin
                    s.esc = 1'b0;
                end
                else if (c == dsl_pkg::CH_BSLASH)
                begin
                    s.esc = 1'b1;
                end
                else if (c == dsl_pkg::CH_QUOTE)
                begin
                    s.ph = PH_TYPE;
                end
                else if (st_reg.rec && (c == dsl_pkg::CH_LBRACE || c == dsl_pkg::CH_RBRACE))
                begin
                    s = syn_err(s);
                end
            end
            PH_TYPE:
            begin
                if (tw != dsl_pkg::WIDTH_NONE)
                begin
                    s.w   = tw;
                    s.cnt = '0;
                    s.ph  = PH_AFTER_TYPE;
                end
                else
                begin
                    s = syn_err(s);
                end
            end
            PH_AFTER_TYPE:
            begin
                if (c == dsl_pkg::CH_LBRACKET)
                begin
                    s.cnt = '0;
                    s.ph  = PH_COUNT_FIRST;
                end
                else if (c == dsl_pkg::CH_LPAREN)
                begin
                    s.esc = 1'b0;
                    s.ph  = PH_LIMIT;
                end
                else
                begin
                    do_finish = 1'b1;
                    do_start  = st_reg.rec;
                end
            end
            PH_COUNT_FIRST, PH_COUNT_MORE:
            begin
                if (c inside {[dsl_pkg::CH_DIGIT_0:dsl_pkg::CH_DIGIT_9]})
                begin
                    if (acc > ACC_W'(CNT_MAX))
                    begin
                        s.cnt = CNT_MAX;
                        s.err = flag_ovf(s.err);
                    end
                    else
                    begin
                        s.cnt = acc[COUNT_BITS-1:0];
                    end
                    s.ph = PH_COUNT_MORE;
                end
                else if (c == dsl_pkg::CH_RBRACKET && st_reg.ph == PH_COUNT_MORE)
                begin
                    s.ph = PH_AFTER_COUNT;
                end
                else
                begin
                    s = syn_err(s);
                end
            end
            PH_AFTER_COUNT:
            begin
                if (c == dsl_pkg::CH_LPAREN)
                begin
                    s.esc = 1'b0;
                    s.ph  = PH_LIMIT;
                end
                else
                begin
                    do_finish = 1'b1;
                    do_start  = st_reg.rec;
                end
            end
            PH_LIMIT:
            begin
                if (st_reg.esc)
                begin
                    s.esc = 1'b0;
                end
                else if (c == dsl_pkg::CH_BSLASH)
                begin
                    s.esc = 1'b1;
                end
                else if (c == dsl_pkg::CH_RPAREN)
                begin
                    do_finish = 1'b1;
                end
                else if (st_reg.rec && (c == dsl_pkg::CH_LBRACE || c == dsl_pkg::CH_RBRACE))
                begin
                    s = syn_err(s);
                end
            end
            default:
            begin
            end
        endcase

        if (do_finish)
        begin
            s = finish_elem(s);
        end
        if (do_start)
        begin
            s = start_elem(s, c);
        end

        // End of text: close an element that may legally end here, else fail.
        if (word.last)
        begin
            case (s.ph)
                PH_DONE, PH_ERROR:
                begin
                end
                PH_AFTER_TYPE, PH_AFTER_COUNT, PH_LIMIT:
                begin
                    s = s.rec ? syn_err(s) : finish_elem(s);
                end
                default:
                begin
                    s = syn_err(s);
                end
            endcase
        end
        stepped = s;
    end

    assign take        = word_valid && (!word.last || out_free);
    assign result_load = take && word.last;

    assign res_length = (stepped.err == dsl_pkg::ST_SYNTAX) ? '0 : stepped.len;
    assign res_count  = (stepped.err == dsl_pkg::ST_SYNTAX) ? '0 : stepped.elc;
    assign res_record = stepped.rec;
    assign res_status = stepped.err;

    assign st_next = take ? (word.last ? ST_RESET : stepped) : st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RESET;
        end
        else
        begin
            st_reg <= st_next;
        end
    end

endmodule

// ----- src/dsl_out_stage.sv -----
// Result register that holds one parse result until it is taken.
module dsl_out_stage
#(
    parameter int LENGTH_BITS        = dsl_pkg::LENGTH_BITS_DEF,
    parameter int ELEMENT_COUNT_BITS = dsl_pkg::ELEMENT_COUNT_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [LENGTH_BITS-1:0]        res_length,
    input  logic [ELEMENT_COUNT_BITS-1:0] res_count,
    input  logic                          res_record,
    input  dsl_pkg::status_t              res_status,
    input  logic                          out_ready,
    output logic                          out_free,
    output logic                          out_valid,
    output logic [LENGTH_BITS-1:0]        packed_length,
    output logic [ELEMENT_COUNT_BITS-1:0] element_count,
    output logic                          is_record,
    output logic [1:0]                    status
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [LENGTH_BITS-1:0]        length_reg;
    logic [ELEMENT_COUNT_BITS-1:0] count_reg;
    logic                          record_reg;
    dsl_pkg::status_t              status_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            length_reg <= res_length;
            count_reg  <= res_count;
            record_reg <= res_record;
            status_reg <= res_status;
        end
    end

    assign out_valid     = valid_reg;
    assign packed_length = length_reg;
    assign element_count = count_reg;
    assign is_record     = record_reg;
    assign status        = status_reg;

endmodule
